[hdl/dna_motif_read_counter_core_defines.svh]
// Assertion macros used by the motif read counter tally module.
`ifndef DNA_MOTIF_READ_COUNTER_CORE_DEFINES_SVH
`define DNA_MOTIF_READ_COUNTER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define DMRC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle.
`define DMRC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/dmrc_pkg.sv]
// Types, constants and helper functions for the motif read counter.
package dmrc_pkg;

  localparam int BASE_W = 4;
  localparam int LEN_W = 4;
  localparam int MOTIF_SLOTS = 4;
  localparam int MOTIF_BASES = 12;
  localparam int MOTIF_W = MOTIF_BASES * BASE_W;
  localparam int OUT_CNT_W = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = MOTIF_W;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 168;

  localparam int DEF_NUM_MOTIFS = 4;
  localparam int DEF_MAX_MOTIF_LEN = 12;
  localparam int DEF_COUNT_WIDTH = 32;

  localparam logic [BASE_W-1:0] CODE_N = 4'hF;

  localparam logic [CFG_INDEX_W-1:0] CFG_MOTIF_BASES_FIRST = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTIF_LENGTH_FIRST = 3'd4;

  typedef struct packed {
    logic [MOTIF_W-1:0] bases;
    logic [LEN_W-1:0]   len;
  } motif_cfg_t;

  typedef struct packed {
    logic [MOTIF_SLOTS-1:0] fwd;
    logic [MOTIF_SLOTS-1:0] rc;
  } cell_match_t;

  typedef struct packed {
    logic [MOTIF_SLOTS-1:0] hits;
    logic                   unknown;
  } tally_in_t;

  function automatic logic [BASE_W-1:0] mirror4(input logic [BASE_W-1:0] c);
    return {c[0], c[1], c[2], c[3]};
  endfunction

  function automatic logic [BASE_W-1:0] motif_nibble(input logic [MOTIF_W-1:0] bases,
                                                     input logic [LEN_W-1:0] pos);
    logic [BASE_W-1:0] r;
    r = '0;
    if (pos < LEN_W'(MOTIF_BASES)) begin
      r = bases[{pos, 2'b00} +: BASE_W];
    end
    return r;
  endfunction

endpackage

[hdl/dna_motif_read_counter_core.sv]
// Top level: configuration registers, the chain of window cells and the tally stage.
// Throughput: one base per cycle; results do not stall the input unless a read end
// meets a result that is still waiting to be taken.
// Result path: the edge that accepts a read's last base loads the window cells and the
// tally's s1 flags; m_tvalid rises when that s1 entry is consumed (a held result stalls it).
// Reset clears the window, per-read flags, counters and motif registers (all slots off).
module dna_motif_read_counter_core #(
  parameter int NUM_MOTIFS = dmrc_pkg::DEF_NUM_MOTIFS,
  parameter int MAX_MOTIF_LEN = dmrc_pkg::DEF_MAX_MOTIF_LEN,
  parameter int COUNT_WIDTH = dmrc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dmrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dmrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // base_code [3:0], zeros [7:4]
  input  logic [dmrc_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // read_kept [0], hit_mask [4:1], reads_counted [36:5], motif0_hits [68:37],
  // motif1_hits [100:69], motif2_hits [132:101], motif3_hits [164:133], zeros [167:165]
  output logic [dmrc_pkg::M_TDATA_W-1:0]      m_tdata
);
  import dmrc_pkg::*;

  motif_cfg_t             cfg [MOTIF_SLOTS];
  logic                   accept;
  logic                   read_start;
  logic [BASE_W-1:0]      cell_base [MAX_MOTIF_LEN];
  logic                   cell_valid [MAX_MOTIF_LEN];
  cell_match_t            cell_match [MAX_MOTIF_LEN];
  tally_in_t              ev;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MOTIF_SLOTS; k++) begin
        cfg[k] <= '0;
      end
      read_start <= 1'b1;
    end else begin
      if (cfg_we) begin
        if (cfg_index < CFG_MOTIF_LENGTH_FIRST) begin
          cfg[cfg_index[1:0]].bases <= cfg_data;
        end else begin
          cfg[cfg_index[1:0]].len <= cfg_data[LEN_W-1:0];
        end
      end
      if (accept) begin
        read_start <= s_tlast;
      end
    end
  end

  for (genvar i = 0; i < MAX_MOTIF_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      dmrc_cell #(.CELL_IDX(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .start    (1'b0),
        .base_in  (s_tdata[BASE_W-1:0]),
        .valid_in (1'b1),
        .cfg      (cfg),
        .base     (cell_base[i]),
        .valid    (cell_valid[i]),
        .match    (cell_match[i])
      );
    end else begin : g_body
      dmrc_cell #(.CELL_IDX(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .start    (read_start),
        .base_in  (cell_base[i-1]),
        .valid_in (cell_valid[i-1]),
        .cfg      (cfg),
        .base     (cell_base[i]),
        .valid    (cell_valid[i]),
        .match    (cell_match[i])
      );
    end
  end

  always_comb begin
    logic f;
    logic r;
    ev.hits = '0;
    ev.unknown = cell_base[0] == CODE_N;
    for (int k = 0; k < MOTIF_SLOTS; k++) begin
      f = 1'b1;
      r = 1'b1;
      for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
        f = f & cell_match[i].fwd[k];
        r = r & cell_match[i].rc[k];
      end
      ev.hits[k] = (k < NUM_MOTIFS) && (cfg[k].len != '0) &&
                   ({1'b0, cfg[k].len} <= (LEN_W+1)'(MAX_MOTIF_LEN)) && (f || r);
    end
  end

  dmrc_tally #(.COUNT_WIDTH(COUNT_WIDTH)) u_tally (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .last_in  (s_tlast),
    .ev       (ev),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[hdl/dmrc_cell.sv]
// One window position: holds a base and compares it against every motif slot.
module dmrc_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift,
  input  logic                                start,
  input  logic [dmrc_pkg::BASE_W-1:0]         base_in,
  input  logic                                valid_in,
  input  dmrc_pkg::motif_cfg_t                cfg [dmrc_pkg::MOTIF_SLOTS],
  output logic [dmrc_pkg::BASE_W-1:0]         base,
  output logic                                valid,
  output dmrc_pkg::cell_match_t               match
);
  import dmrc_pkg::*;

  localparam logic [LEN_W-1:0] IDX = LEN_W'(CELL_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in && !start;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      base <= base_in;
    end
  end

  always_comb begin
    logic need;
    logic [LEN_W-1:0] fpos;
    match = '0;
    for (int k = 0; k < MOTIF_SLOTS; k++) begin
      need = IDX < cfg[k].len;
      fpos = cfg[k].len - IDX - LEN_W'(1);
      match.fwd[k] = !need || (valid && base == motif_nibble(cfg[k].bases, fpos));
      match.rc[k] = !need || (valid && base == mirror4(motif_nibble(cfg[k].bases, IDX)));
    end
  end

endmodule

[hdl/dmrc_tally.sv]
// Per-read flag accumulation, saturating counters and the result register.
module dmrc_tally #(
  parameter int COUNT_WIDTH = dmrc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             last_in,
  input  dmrc_pkg::tally_in_t              ev,
  output logic                             in_ready,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dmrc_pkg::M_TDATA_W-1:0]   m_tdata
);
  import dmrc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   s1_valid;
  logic                   s1_last;
  logic                   consume;
  logic [MOTIF_SLOTS-1:0] flags;
  logic                   unk;
  logic [MOTIF_SLOTS-1:0] flags_acc;
  logic                   unk_acc;
  logic [COUNT_WIDTH-1:0] reads_cnt;
  logic [COUNT_WIDTH-1:0] motif_cnt [MOTIF_SLOTS];
  logic                   out_kept;
  logic [MOTIF_SLOTS-1:0] out_mask;

  assign consume = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign in_ready = !s1_valid || consume;
  assign flags_acc = flags | ev.hits;
  assign unk_acc = unk | ev.unknown;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last <= 1'b0;
      flags <= '0;
      unk <= 1'b0;
      reads_cnt <= '0;
      for (int k = 0; k < MOTIF_SLOTS; k++) begin
        motif_cnt[k] <= '0;
      end
      m_tvalid <= 1'b0;
      out_kept <= 1'b0;
      out_mask <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_last <= last_in;
      end else if (consume) begin
        s1_valid <= 1'b0;
      end
      if (consume && s1_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (consume) begin
        if (!s1_last) begin
          flags <= flags_acc;
          unk <= unk_acc;
        end else begin
          flags <= '0;
          unk <= 1'b0;
          out_kept <= !unk_acc;
          out_mask <= unk_acc ? '0 : flags_acc;
          if (!unk_acc) begin
            reads_cnt <= (reads_cnt == CNT_MAX) ? reads_cnt : reads_cnt + 1'b1;
            for (int k = 0; k < MOTIF_SLOTS; k++) begin
              if (flags_acc[k] && motif_cnt[k] != CNT_MAX) begin
                motif_cnt[k] <= motif_cnt[k] + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign m_tdata = {3'b000,
                    OUT_CNT_W'(motif_cnt[3]), OUT_CNT_W'(motif_cnt[2]),
                    OUT_CNT_W'(motif_cnt[1]), OUT_CNT_W'(motif_cnt[0]),
                    OUT_CNT_W'(reads_cnt), out_mask, out_kept};

  `include "dna_motif_read_counter_core_defines.svh"

  `DMRC_ASSERT_IMPLY(a_drop_mask_zero, m_tvalid && !out_kept, out_mask == '0, "dropped read shows hits")
  `DMRC_ASSERT_IMPLY(a_stall_cause, !in_ready, s1_valid && s1_last && m_tvalid, "input stalled without a full result")
  `DMRC_ASSERT_ALWAYS(a_m0_le_reads, motif_cnt[0] <= reads_cnt, "motif 0 count above read count")
  `DMRC_ASSERT_ALWAYS(a_m3_le_reads, motif_cnt[3] <= reads_cnt, "motif 3 count above read count")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the motif read counter: reads streamed in, tallies checked.
module tb;
  import dmrc_pkg::*;

  typedef struct packed {
    bit             kept;
    bit [3:0]       hits;
    bit [31:0]      reads;
    bit [3:0][31:0] per_motif;
  } tally_t;

  class read_tally_board;
    bit [47:0] motif_bases [4];
    bit [3:0]  motif_len [4];
    bit [3:0]  recent [12];
    int        fill;
    bit        saw_n;
    bit [3:0]  flags;
    bit [31:0] kept_reads;
    bit [31:0] motif_totals [4];
    tally_t    tallies [$];
    int        errors;

    function new();
      for (int k = 0; k < 4; k++) begin
        motif_bases[k] = '0;
        motif_len[k] = '0;
        motif_totals[k] = '0;
      end
      for (int i = 0; i < 12; i++) recent[i] = '0;
      fill = 0;
      saw_n = 0;
      flags = '0;
      kept_reads = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < CFG_MOTIF_LENGTH_FIRST) motif_bases[idx] = data;
      else motif_len[idx - CFG_MOTIF_LENGTH_FIRST] = data[3:0];
    endfunction

    function bit [3:0] nib(int k, int pos);
      return motif_bases[k][4*pos +: 4];
    endfunction

    function bit tail_hit(int k, bit rc);
      int len;
      bit [3:0] want;
      len = motif_len[k];
      if (len == 0 || len > 12 || fill < len) return 0;
      for (int j = 0; j < len; j++) begin
        want = rc ? mirror4(nib(k, len - 1 - j)) : nib(k, j);
        if (recent[len - 1 - j] != want) return 0;
      end
      return 1;
    endfunction

    function void note_base(bit [3:0] code, bit last);
      tally_t t;
      for (int i = 11; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = code;
      if (fill < 12) fill++;
      if (code == CODE_N) saw_n = 1;
      for (int k = 0; k < 4; k++)
        if (tail_hit(k, 0) || tail_hit(k, 1)) flags[k] = 1;
      if (!last) return;
      if (!saw_n) begin
        if (kept_reads != '1) kept_reads++;
        for (int k = 0; k < 4; k++)
          if (flags[k] && motif_totals[k] != '1) motif_totals[k]++;
      end
      t.kept = !saw_n;
      t.hits = saw_n ? 4'b0 : flags;
      t.reads = kept_reads;
      for (int k = 0; k < 4; k++) t.per_motif[k] = motif_totals[k];
      tallies = {tallies, t};
      for (int i = 0; i < 12; i++) recent[i] = '0;
      fill = 0;
      saw_n = 0;
      flags = '0;
    endfunction

    function int pending();
      return tallies.size();
    endfunction

    function void check_tally(logic [M_TDATA_W-1:0] d);
      tally_t want;
      if (tallies.size() == 0) begin
        $error("result arrived with no read end pending: %h", d);
        errors++;
        return;
      end
      want = tallies.pop_front();
      if (d[0] !== want.kept) begin
        $error("read_kept expected %0h actual %0h", want.kept, d[0]);
        errors++;
      end
      if (d[4:1] !== want.hits) begin
        $error("hit_mask expected %0h actual %0h", want.hits, d[4:1]);
        errors++;
      end
      if (d[36:5] !== want.reads) begin
        $error("reads_counted expected %0d actual %0d", want.reads, d[36:5]);
        errors++;
      end
      for (int k = 0; k < 4; k++)
        if (d[37 + 32*k +: 32] !== want.per_motif[k]) begin
          $error("motif%0d_hits expected %0d actual %0d", k, want.per_motif[k],
                 d[37 + 32*k +: 32]);
          errors++;
        end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;

  read_tally_board sb = new();
  bit              calm = 1'b0;
  int              bases_sent = 0;
  logic [3:0]      read_bases [$];

  dna_motif_read_counter_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [3:0] random_base(bit noise);
    if (noise) return 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) != 0) return 4'(1 << $urandom_range(0, 3));
    return 4'($urandom_range(0, 14));
  endfunction

  function automatic logic [47:0] acgt_motif();
    logic [47:0] m;
    for (int i = 0; i < 12; i++) m[4*i +: 4] = 4'(1 << $urandom_range(0, 3));
    return m;
  endfunction

  task automatic program_motifs(input logic [47:0] bases [4], input logic [3:0] lens [4]);
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    for (int r = 0; r < 8; r++) begin
      if (r < 4) begin
        idx = CFG_MOTIF_BASES_FIRST + CFG_INDEX_W'(r);
        data = bases[r];
      end else begin
        idx = CFG_MOTIF_LENGTH_FIRST + CFG_INDEX_W'(r - 4);
        data = {44'({$urandom(), $urandom()}), lens[r - 4]};
      end
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      @(negedge clk);
      sb.set_reg(idx, data);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_base(input logic [3:0] code, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, code};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_base(code, last);
    bases_sent++;
    @(negedge clk);
  endtask

  task automatic send_read();
    for (int i = 0; i < read_bases.size(); i++)
      push_base(read_bases[i], i == read_bases.size() - 1);
  endtask

  task automatic add_motif(input int slot, input bit rc);
    int len;
    len = sb.motif_len[slot];
    for (int j = 0; j < len; j++)
      read_bases = {read_bases,
                    rc ? mirror4(sb.nib(slot, len - 1 - j)) : sb.nib(slot, j)};
  endtask

  task automatic build_read();
    int  len;
    int  slot;
    int  mlen;
    int  at;
    bit  rc;
    bit  noise;
    read_bases.delete();
    noise = ($urandom_range(0, 19) == 0);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
    for (int i = 0; i < len; i++) read_bases = {read_bases, random_base(noise)};
    if (!noise && $urandom_range(0, 9) < 6) begin
      slot = $urandom_range(0, 3);
      mlen = sb.motif_len[slot];
      if (mlen >= 1 && mlen <= 12) begin
        while (read_bases.size() < mlen) read_bases = {read_bases, random_base(0)};
        at = $urandom_range(0, read_bases.size() - mlen);
        rc = $urandom_range(0, 1);
        for (int j = 0; j < mlen; j++)
          read_bases[at + j] = rc ? mirror4(sb.nib(slot, mlen - 1 - j)) : sb.nib(slot, j);
      end
    end
    if ($urandom_range(0, 9) == 0)
      read_bases[$urandom_range(0, read_bases.size() - 1)] = CODE_N;
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    while (sb.pending() > 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_tally(m_tdata);
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [47:0] bases [4];
    logic [3:0]  lens [4];
    int          phase;
    int          phase_start;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    bases[0] = 48'h8_4_2_1_1_2_4_8_8_4_2_1;
    bases[1] = 48'h0_0_0_0_0_0_0_0_4_2_1_1;
    bases[2] = 48'h0_0_0_0_0_0_0_0_0_0_0_8;
    bases[3] = 48'h1_1_1_1_1_1_1_1_1_1_1_1;
    lens = '{4'd12, 4'd4, 4'd1, 4'd15};
    program_motifs(bases, lens);
    read_bases.delete();
    add_motif(0, 0);
    send_read();
    read_bases.delete();
    add_motif(1, 1);
    send_read();
    read_bases = '{4'h0, CODE_N, 4'h8};
    send_read();
    read_bases = '{4'h8};
    send_read();
    s_tvalid <= 1'b0;
    settle();

    phase = 0;
    while (bases_sent < 1320) begin
      for (int k = 0; k < 4; k++) begin
        bases[k] = (phase % 4 == 3) ? 48'({$urandom(), $urandom()}) : acgt_motif();
        case (phase)
          0: lens[k] = 4'd12;
          1: lens[k] = 4'd1;
          2: lens[k] = (k == 0) ? 4'd0 : (k == 1) ? 4'd15 : (k == 2) ? 4'd13 : 4'd12;
          default: lens[k] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(2, 8));
        endcase
      end
      if (phase == 2) bases[1] = '1;
      calm = ($urandom_range(0, 3) == 0);
      program_motifs(bases, lens);
      phase_start = bases_sent;
      while (bases_sent - phase_start < 200 && bases_sent < 1320) begin
        build_read();
        send_read();
      end
      s_tvalid <= 1'b0;
      settle();
      phase++;
    end

    calm = 1'b0;
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      if (sb.pending() > 0) $error("%0d read results never arrived", sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
